>>> design/ngcs_pkg.sv
package ngcs_pkg;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 4096;

    // Field widths
    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int LON_W    = 16;
    localparam int LAT_W    = 15;
    localparam int DIST_W   = 15;
    localparam int ENTRY_W  = LON_W + LAT_W;

    // Distance arithmetic
    localparam int MAG_W    = 15;            // wrapped |dlon| and |dlat|
    localparam int SQ_W     = 2 * MAG_W;     // one squared term
    localparam int D2_W     = SQ_W + 1;      // sum of two squares
    localparam int WRAP_SPAN = 36000;
    localparam int HALF_SPAN = 18000;
    localparam int DIST_SAT  = 32767;

    // Square root chain: one result bit per cell
    localparam int ROOT_STEPS = 16;
    localparam int ROOT_X_W   = 2 * ROOT_STEPS;
    localparam int REM_W      = ROOT_STEPS + 2;

    // Operation codes carried in tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Word handed from one root cell to the next
    typedef struct packed {
        logic                  valid;
        logic [ROOT_X_W-1:0]   x;
        logic [REM_W-1:0]      rem;
        logic [ROOT_STEPS-1:0] q;
    } root_word_t;

endpackage

>>> design/ngcs_table.sv
module ngcs_table import ngcs_pkg::*; #(
    parameter int DEPTH  = MAX_ENTRIES_DEF,
    parameter int ADDR_W = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output logic               rd_valid,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [0:DEPTH-1];
    logic               rd_valid_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    assign rd_valid = rd_valid_reg;

endmodule

>>> design/ngcs_dist.sv
module ngcs_dist import ngcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [ENTRY_W-1:0] entry,      // lon, lat from the lowest bit up
    input  logic [LON_W-1:0]   q_lon,
    input  logic [LAT_W-1:0]   q_lat,
    output logic               out_valid,
    output logic [D2_W-1:0]    out_d2
);

    logic [LON_W-1:0] t_lon;
    logic [LAT_W-1:0] t_lat;
    logic [LON_W:0]   dlon;
    logic [LON_W-1:0] dlon_abs;
    logic [LON_W-1:0] dlon_wrap;
    logic [LAT_W:0]   dlat;
    logic [LAT_W:0]   dlat_abs;

    logic             va_reg, vb_reg, vc_reg;
    logic [MAG_W-1:0] mlon_reg, mlat_reg;
    logic [SQ_W-1:0]  sqlon_reg, sqlat_reg;
    logic [D2_W-1:0]  d2_reg;

    assign t_lon = entry[LON_W-1:0];
    assign t_lat = entry[ENTRY_W-1:LON_W];

    // Differences, magnitudes and longitude wrap
    always_comb begin
        dlon = {q_lon[LON_W-1], q_lon} - {t_lon[LON_W-1], t_lon};
        dlon_abs = dlon[LON_W] ? LON_W'(-dlon) : dlon[LON_W-1:0];
        if (dlon_abs <= LON_W'(HALF_SPAN)) begin
            dlon_wrap = dlon_abs;
        end else if (dlon_abs <= LON_W'(WRAP_SPAN)) begin
            dlon_wrap = LON_W'(WRAP_SPAN) - dlon_abs;
        end else begin
            // beyond a full turn the wrapped value goes negative: keep its size
            dlon_wrap = dlon_abs - LON_W'(WRAP_SPAN);
        end
        dlat = {q_lat[LAT_W-1], q_lat} - {t_lat[LAT_W-1], t_lat};
        dlat_abs = dlat[LAT_W] ? (~dlat + 1'b1) : dlat;
    end

    // Stage A: magnitudes
    always_ff @(posedge aclk) begin
        mlon_reg <= dlon_wrap[MAG_W-1:0];
        mlat_reg <= dlat_abs[MAG_W-1:0];
    end

    // Stage B: squares
    always_ff @(posedge aclk) begin
        sqlon_reg <= {{MAG_W{1'b0}}, mlon_reg} * {{MAG_W{1'b0}}, mlon_reg};
        sqlat_reg <= {{MAG_W{1'b0}}, mlat_reg} * {{MAG_W{1'b0}}, mlat_reg};
    end

    // Stage C: sum
    always_ff @(posedge aclk) begin
        d2_reg <= {1'b0, sqlon_reg} + {1'b0, sqlat_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_d2    = d2_reg;

endmodule

>>> design/ngcs_root_cell.sv
module ngcs_root_cell import ngcs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  root_word_t in_word,
    output root_word_t out_word
);

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      rem_new;
    logic [ROOT_STEPS-1:0] q_new;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_STEPS-1:0] q_reg;
    logic [ROOT_X_W-1:0]   x_reg;
    logic                  valid_reg;

    // One root bit: bring down the next bit pair, try 4q+1
    always_comb begin
        rem_sh = {in_word.rem, in_word.x[ROOT_X_W-1:ROOT_X_W-2]};
        trial  = {2'b00, in_word.q, 2'b01};
        if (rem_sh >= trial) begin
            rem_new = rem_sh - trial;
            q_new   = {in_word.q[ROOT_STEPS-2:0], 1'b1};
        end else begin
            rem_new = rem_sh;
            q_new   = {in_word.q[ROOT_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_new[REM_W-1:0];
        q_reg   <= q_new;
        x_reg   <= {in_word.x[ROOT_X_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= in_word.valid;
        end
    end

    assign out_word.valid = valid_reg;
    assign out_word.x     = x_reg;
    assign out_word.rem   = rem_reg;
    assign out_word.q     = q_reg;

endmodule

>>> design/nearest_grid_cell_search.sv
// Nearest grid cell search.
// Slave stream words either load one table entry (tuser = 0) or run a query
// (tuser = 1). s_tdata carries entry_index, lon, lat from the lowest bit up.
// A load gives no result and leaves the block idle. A query compares the
// point with entries 0 .. n-1, n = min(entry_count, MAX_ENTRIES), reading
// the table memory one entry per cycle through the distance pipeline
// (stages A, B, C), then takes the minimum through a chain of sixteen
// root cells, one result bit per cell. The result goes from the ROOT state
// (from idle for an empty table) to DELIVER, which loads the output register
// and returns to idle; no new word is taken while a query is in progress.
// The result waits in the master output register; a stalled receiver does
// not stop the next word being taken, and a second result holds in the
// block until the first is gone. cfg_we writes entry_count from cfg_wdata;
// the user does so only while the block is idle, which the block does not
// enforce. Reset (aresetn low, synchronous) clears entry_count and all
// control state; table contents stay undefined until loaded.
module nearest_grid_cell_search import ngcs_pkg::*; #(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,   // entry_count
    // slave stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,     // entry_index[11:0], lon[27:12], lat[42:28]
    input  logic               s_tuser,     // op
    // master stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,     // nearest_index[11:0], distance[26:12]
    output logic               m_tuser      // empty_table
);

    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W  = 17;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_ROOT    = 2'd2;
    localparam logic [1:0] ST_DELIVER = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [COUNT_W-1:0] entry_count_reg;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]   cmp_cnt_reg, cmp_cnt_next;
    logic [LON_W-1:0]   q_lon_reg;
    logic [LAT_W-1:0]   q_lat_reg;
    logic [D2_W-1:0]    best_reg, best_next;
    logic [ADDR_W-1:0]  best_idx_reg, best_idx_next;
    logic               root_go_reg, root_go_next;
    logic [INDEX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [DIST_W-1:0]  pend_dist_reg, pend_dist_next;
    logic               pend_empty_reg, pend_empty_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [INDEX_W-1:0] m_idx_reg;
    logic [DIST_W-1:0]  m_dist_reg;
    logic               m_empty_reg;
    logic               m_load;

    logic [INDEX_W-1:0] in_index;
    logic [LON_W-1:0]   in_lon;
    logic [LAT_W-1:0]   in_lat;
    logic               s_accept;
    logic [EXT_W-1:0]   ld_addr_ext;
    logic [EXT_W-1:0]   count_ext;
    logic [EXT_W-1:0]   count_lim;
    logic [EXT_W-1:0]   best_idx_ext;
    logic               tab_wr_en;
    logic               tab_rd_en;
    logic               tab_rd_valid;
    logic [ENTRY_W-1:0] tab_rd_data;
    logic               d_valid;
    logic [D2_W-1:0]    d_d2;
    root_word_t         chain_w [0:ROOT_STEPS];

    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_lon   = s_tdata[INDEX_W+LON_W-1:INDEX_W];
    assign in_lat   = s_tdata[INDEX_W+ENTRY_W-1:INDEX_W+LON_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Loads to slots beyond the table are dropped
    assign ld_addr_ext = {{(EXT_W-INDEX_W){1'b0}}, in_index};
    assign tab_wr_en   = s_accept && (s_tuser == OP_LOAD)
                         && (ld_addr_ext < EXT_W'(MAX_ENTRIES));

    // Searched count clipped to the table depth
    assign count_ext = {{(EXT_W-COUNT_W){1'b0}}, entry_count_reg};
    assign count_lim = (count_ext > EXT_W'(MAX_ENTRIES)) ? EXT_W'(MAX_ENTRIES) : count_ext;

    assign tab_rd_en = (state_reg == ST_SCAN) && (issue_cnt_reg < n_reg);

    ngcs_table #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (tab_wr_en),
        .wr_addr  (ld_addr_ext[ADDR_W-1:0]),
        .wr_data  ({in_lat, in_lon}),
        .rd_en    (tab_rd_en),
        .rd_addr  (issue_cnt_reg[ADDR_W-1:0]),
        .rd_valid (tab_rd_valid),
        .rd_data  (tab_rd_data)
    );

    ngcs_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tab_rd_valid),
        .entry     (tab_rd_data),
        .q_lon     (q_lon_reg),
        .q_lat     (q_lat_reg),
        .out_valid (d_valid),
        .out_d2    (d_d2)
    );

    // Root chain, fed with the minimum once the scan is done
    assign chain_w[0].valid = root_go_reg;
    assign chain_w[0].x     = {{(ROOT_X_W-D2_W){1'b0}}, best_reg};
    assign chain_w[0].rem   = '0;
    assign chain_w[0].q     = '0;

    for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
        ngcs_root_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_word  (chain_w[g]),
            .out_word (chain_w[g+1])
        );
    end

    assign best_idx_ext = EXT_W'(best_idx_reg);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        issue_cnt_next  = issue_cnt_reg;
        cmp_cnt_next    = cmp_cnt_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        root_go_next    = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_dist_next  = pend_dist_reg;
        pend_empty_next = pend_empty_reg;
        m_load          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_tuser == OP_QUERY)) begin
                    n_next         = count_lim[CNT_W-1:0];
                    issue_cnt_next = '0;
                    cmp_cnt_next   = '0;
                    if (count_lim == '0) begin
                        pend_idx_next   = '0;
                        pend_dist_next  = DIST_W'(DIST_SAT);
                        pend_empty_next = 1'b1;
                        state_next      = ST_DELIVER;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (tab_rd_en) begin
                    issue_cnt_next = issue_cnt_reg + 1'b1;
                end
                // first minimum wins ties
                if (d_valid) begin
                    if ((cmp_cnt_reg == '0) || (d_d2 < best_reg)) begin
                        best_next     = d_d2;
                        best_idx_next = cmp_cnt_reg[ADDR_W-1:0];
                    end
                    cmp_cnt_next = cmp_cnt_reg + 1'b1;
                    if (cmp_cnt_reg == n_reg - 1'b1) begin
                        root_go_next = 1'b1;
                        state_next   = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (chain_w[ROOT_STEPS].valid) begin
                    pend_idx_next   = best_idx_ext[INDEX_W-1:0];
                    pend_dist_next  = (chain_w[ROOT_STEPS].q > ROOT_STEPS'(DIST_SAT))
                                      ? DIST_W'(DIST_SAT)
                                      : chain_w[ROOT_STEPS].q[DIST_W-1:0];
                    pend_empty_next = 1'b0;
                    state_next      = ST_DELIVER;
                end
            end
            ST_DELIVER: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_load     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            n_reg           <= '0;
            issue_cnt_reg   <= '0;
            cmp_cnt_reg     <= '0;
            root_go_reg     <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            issue_cnt_reg <= issue_cnt_next;
            cmp_cnt_reg   <= cmp_cnt_next;
            root_go_reg   <= root_go_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_we) begin
                entry_count_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        pend_idx_reg   <= pend_idx_next;
        pend_dist_reg  <= pend_dist_next;
        pend_empty_reg <= pend_empty_next;
        if (s_accept && (s_tuser == OP_QUERY)) begin
            q_lon_reg <= in_lon;
            q_lat_reg <= in_lat;
        end
        if (m_load) begin
            m_idx_reg   <= pend_idx_reg;
            m_dist_reg  <= pend_dist_reg;
            m_empty_reg <= pend_empty_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_dist_reg, m_idx_reg};
    assign m_tuser  = m_empty_reg;

    // Checks
    a_dist_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        d_valid |-> (state_reg == ST_SCAN))
        else $error("distance word outside a scan");

    a_root_in_root: assert property (@(posedge aclk) disable iff (!aresetn)
        chain_w[ROOT_STEPS].valid |-> (state_reg == ST_ROOT))
        else $error("root result outside root phase");

    a_cmp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (cmp_cnt_reg < n_reg))
        else $error("compare count past entry count");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= n_reg))
        else $error("read address past entry count");

    a_empty_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_dist_reg == DIST_W'(DIST_SAT)))
        else $error("empty table result not saturated");

endmodule

>>> tb/sv/tb_nearest_grid_cell_search.sv
`timescale 1ns / 100ps

// One expected result word
typedef struct packed {
    logic [11:0] index;
    logic [14:0] distance;
    logic        empty;
} cell_answer_t;

// Scoreboard: mirrors the table and entry count, predicts each query's answer
class nearest_cell_board;
    int unsigned  entry_count;
    int           lon_mem [ngcs_pkg::MAX_ENTRIES_DEF];
    int           lat_mem [ngcs_pkg::MAX_ENTRIES_DEF];
    cell_answer_t pending_answers [$];
    int unsigned  errors;

    function new();
        entry_count = 0;
        errors      = 0;
    endfunction

    // floor square root, one result bit at a time from the top
    function automatic longint floor_root(longint x);
        longint r;
        longint t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= x) r = t;
        end
        return r;
    endfunction

    function automatic cell_answer_t search_nearest(int q_lon, int q_lat);
        cell_answer_t ans;
        int unsigned  n;
        longint       dlon, dlat, d2, best;
        int unsigned  best_i;
        longint       root;
        n = (entry_count > ngcs_pkg::MAX_ENTRIES_DEF) ? ngcs_pkg::MAX_ENTRIES_DEF
                                                      : entry_count;
        // empty table: saturated distance, flag set
        if (n == 0) begin
            ans.index    = '0;
            ans.distance = 15'(ngcs_pkg::DIST_SAT);
            ans.empty    = 1'b1;
            return ans;
        end
        best   = -1;
        best_i = 0;
        for (int unsigned i = 0; i < n; i++) begin
            dlon = longint'(q_lon) - longint'(lon_mem[i]);
            dlat = longint'(q_lat) - longint'(lat_mem[i]);
            if (dlon < 0) dlon = -dlon;
            // wrap round the globe; may go negative for out-of-range input
            if (ngcs_pkg::WRAP_SPAN - dlon < dlon) dlon = ngcs_pkg::WRAP_SPAN - dlon;
            d2 = dlat * dlat + dlon * dlon;
            // strict compare keeps the first entry on a tie
            if (best < 0 || d2 < best) begin
                best   = d2;
                best_i = i;
            end
        end
        root = floor_root(best);
        if (root > ngcs_pkg::DIST_SAT) root = ngcs_pkg::DIST_SAT;
        ans.index    = best_i[11:0];
        ans.distance = root[14:0];
        ans.empty    = 1'b0;
        return ans;
    endfunction

    // accepted input word
    function void note_word(logic op, logic [11:0] idx,
                            logic signed [15:0] lon, logic signed [14:0] lat);
        if (op == ngcs_pkg::OP_LOAD) begin
            lon_mem[idx] = lon;
            lat_mem[idx] = lat;
        end else begin
            pending_answers.push_back(search_nearest(lon, lat));
        end
    endfunction

    // accepted result word
    function void check_answer(logic [31:0] tdata, logic tuser);
        cell_answer_t want;
        if (pending_answers.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: index %0d distance %0d empty %0b",
                         tdata[11:0], tdata[26:12], tuser);
            return;
        end
        want = pending_answers.pop_front();
        if (tdata[11:0] !== want.index || tdata[26:12] !== want.distance ||
            tuser !== want.empty) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected index %0d distance %0d empty %0b,",
                         want.index, want.distance, want.empty,
                         " got index %0d distance %0d empty %0b",
                         tdata[11:0], tdata[26:12], tuser);
        end
    endfunction
endclass

module tb_nearest_grid_cell_search;
    import ngcs_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int QUIET_CYCLES    = 40;
    localparam int RANDOM_SEGMENTS = 7;
    localparam int SEGMENT_WORDS   = 18;
    localparam int IDLE_PERCENT    = 17;
    localparam int HOLD_CYCLES     = 400;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [47:0]        s_tdata   = '0;
    logic               s_tuser   = 1'b0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [31:0]        m_tdata;
    logic               m_tuser;

    nearest_cell_board board = new();

    bit          tx_gaps   = 1'b1;
    bit          rx_gaps   = 1'b1;
    int unsigned hold_asks = 0;   // bumped by the stimulus
    int unsigned hold_seen = 0;   // receiver side copy
    int unsigned rx_hold   = 0;
    int unsigned cycle_count = 0;
    bit          written_map [MAX_ENTRIES_DEF];

    nearest_grid_cell_search DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge aclk) begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            rx_hold   = HOLD_CYCLES;
        end
        if (rx_hold > 0) begin
            m_tready = 1'b0;
            rx_hold--;
        end else begin
            m_tready = !(rx_gaps && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // monitor both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_word(s_tuser, s_tdata[11:0], s_tdata[27:12], s_tdata[42:28]);
            if (m_tvalid && m_tready)
                board.check_answer(m_tdata, m_tuser);
        end
    end

    // offer one word and hold it until taken
    task automatic send_word(logic op, logic [11:0] idx, logic [15:0] lon,
                             logic [14:0] lat);
        @(negedge aclk);
        while (tx_gaps && $urandom_range(99) < IDLE_PERCENT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {5'b0, lat, lon, idx};
        if (op == OP_LOAD) written_map[idx] = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drop valid and wait for every outstanding answer
    task automatic wait_all_answers();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending_answers.size() != 0) @(posedge aclk);
    endtask

    task automatic write_entry_count(int unsigned value);
        wait_all_answers();
        // loads give no result, so allow the pipe to settle
        repeat (QUIET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = value[COUNT_W-1:0];
        board.entry_count = value[COUNT_W-1:0];
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // number of entries loaded contiguously from slot 0
    function automatic int unsigned loaded_prefix();
        int unsigned n;
        n = 0;
        while (n < MAX_ENTRIES_DEF && written_map[n]) n++;
        return n;
    endfunction

    function automatic logic [15:0] pick_lon();
        int v;
        if ($urandom_range(99) < 15) return 16'($urandom());
        v = int'($urandom_range(36000)) - 18000;
        return v[15:0];
    endfunction

    function automatic logic [14:0] pick_lat();
        int v;
        if ($urandom_range(99) < 15) return 15'($urandom());
        v = int'($urandom_range(18000)) - 9000;
        return v[14:0];
    endfunction

    // query point, often close to a loaded entry
    task automatic send_query(int unsigned reach);
        int unsigned k;
        int          qlon, qlat;
        if (reach > 0 && $urandom_range(99) < 30) begin
            k    = $urandom_range(reach - 1);
            qlon = board.lon_mem[k] + int'($urandom_range(40)) - 20;
            qlat = board.lat_mem[k] + int'($urandom_range(40)) - 20;
            send_word(OP_QUERY, 12'($urandom()), qlon[15:0], qlat[14:0]);
        end else begin
            send_word(OP_QUERY, 12'($urandom()), pick_lon(), pick_lat());
        end
    endtask

    initial begin
        int unsigned prefix;
        int unsigned lidx;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty table straight after reset
        send_word(OP_QUERY, 12'hFFF, 16'sd100, -15'sd100);

        // table extremes, a duplicate pair for the tie, top slot
        send_word(OP_LOAD, 12'd0, 16'h8000, 15'h4000);
        send_word(OP_LOAD, 12'd1, 16'h7FFF, 15'h3FFF);
        send_word(OP_LOAD, 12'd2, 16'sd0, 15'sd0);
        send_word(OP_LOAD, 12'd3, 16'sd18000, 15'sd9000);
        send_word(OP_LOAD, 12'd4, -16'sd18000, -15'sd9000);
        send_word(OP_LOAD, 12'd5, 16'sd17999, -15'sd8999);
        send_word(OP_LOAD, 12'd6, -16'sd17950, 15'sd50);
        send_word(OP_LOAD, 12'd7, 16'sd0, 15'sd0);
        send_word(OP_LOAD, 12'hFFF, 16'sd1234, -15'sd4321);

        // one entry at the most negative corner: root saturates
        write_entry_count(1);
        send_word(OP_QUERY, 12'd0, 16'h7FFF, 15'h3FFF);

        write_entry_count(8);
        send_word(OP_QUERY, 12'd0, 16'sd0, 15'sd0);              // tie, first wins
        send_word(OP_QUERY, 12'd5, -16'sd18000, 15'sd9000);      // wrap to zero
        send_word(OP_QUERY, 12'd9, 16'sd17990, -15'sd9000);      // across the seam
        send_word(OP_QUERY, 12'hABC, 16'h8000, 15'h3FFF);        // beyond the wrap span
        send_word(OP_QUERY, 12'h543, 16'sd16000, 15'h4000);

        write_entry_count(0);
        send_word(OP_QUERY, 12'd1, 16'sd0, 15'sd0);

        // random: segments at different counts, mixed loads and queries
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
            prefix = loaded_prefix();
            case (seg)
                0: write_entry_count(prefix);
                2: write_entry_count(1);
                4: write_entry_count(0);
                default: write_entry_count($urandom_range(prefix));
            endcase
            tx_gaps = (seg != 1);
            rx_gaps = (seg != 1);
            if (seg == 3) begin
                // receiver holds off while queries keep coming
                @(negedge aclk);
                hold_asks++;
            end
            for (int w = 0; w < SEGMENT_WORDS; w++) begin
                if (seg == 5 && w == SEGMENT_WORDS / 2)
                    wait_all_answers();
                if ($urandom_range(99) < 35) begin
                    if ($urandom_range(99) < 80)
                        lidx = $urandom_range((prefix + 3 < MAX_ENTRIES_DEF) ?
                                              prefix + 3 : MAX_ENTRIES_DEF - 1);
                    else
                        lidx = $urandom_range(MAX_ENTRIES_DEF - 1);
                    send_word(OP_LOAD, lidx[11:0], pick_lon(), pick_lat());
                end else begin
                    send_query(prefix);
                end
            end
        end
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;

        // drain
        wait_all_answers();
        repeat (QUIET_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.pending_answers.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ngcs_pkg.sv
design/ngcs_table.sv
design/ngcs_dist.sv
design/ngcs_root_cell.sv
design/nearest_grid_cell_search.sv
tb/sv/tb_nearest_grid_cell_search.sv
